// ===== design/drcm_pkg.sv =====
// Shared types and constants of the design-region column mapper.
// Used by the divider, the layer cells, the top level and the checker.
package drcm_pkg;

  // Sizing of the layer table and the coordinates
  localparam int MAX_LAYERS   = 8;
  localparam int COORD_BITS   = 12;
  localparam int RESULT_LIMIT = 8;

  // Fixed field widths
  localparam int GRID_W     = 13;
  localparam int CELL_W     = 24;
  localparam int LSEL_W     = 3;
  localparam int XS_W       = 12;
  localparam int LCNT_W     = 4;
  localparam int COL_W      = 27;
  localparam int ML_W       = 3;
  localparam int ZIN_W      = 12;
  localparam int HIN_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Derived widths
  localparam int ZS_W    = COORD_BITS;
  localparam int ZH_W    = COORD_BITS + 1;
  localparam int IZ_W    = GRID_W;
  localparam int PX_W    = GRID_W;
  localparam int ZE_W    = ((ZH_W > IZ_W) ? ZH_W : IZ_W) + 1;
  localparam int XE_W    = GRID_W + 1;
  localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int ACT_W   = (LAYER_W > LCNT_W) ? LAYER_W : LCNT_W;
  localparam int CNT_W   = $clog2(RESULT_LIMIT + 1);

  // Divider: quotient bits retired per cycle and steps per division
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = CELL_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic {
    ACT_MAP  = 1'b0,
    ACT_LOAD = 1'b1
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X  = 3'd0,
    CFG_GRID_Z  = 3'd1,
    CFG_X_START = 3'd2,
    CFG_X_WIDTH = 3'd3,
    CFG_SLAB    = 3'd4,
    CFG_LAYERS  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVZ,
    ST_WALK,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic              action;
    logic [CELL_W-1:0] cell_index;
    logic [LSEL_W-1:0] layer_select;
    logic [ZIN_W-1:0]  layer_z_start_in;
    logic [HIN_W-1:0]  layer_z_height_in;
  } in_t;

  typedef struct packed {
    logic [CELL_W-1:0] row_index;
    logic              hit;
    logic [ML_W-1:0]   matched_layer;
    logic [COL_W-1:0]  column_index;
    logic              last;
  } out_t;

  // Token walking the cell chain
  typedef struct packed {
    logic             valid;
    logic             win;
    logic [IZ_W-1:0]  iz;
    logic [PX_W-1:0]  px;
    logic [COL_W-1:0] base;
  } tok_t;

  // Match report of one cell
  typedef struct packed {
    logic               match;
    logic [LAYER_W-1:0] layer;
    logic [COL_W-1:0]   col;
  } cell_hit_t;

  // Configuration seen by every cell
  typedef struct packed {
    logic              slab;
    logic [GRID_W-1:0] width;
    logic [LCNT_W-1:0] layer_count;
  } cell_cfg_t;

  // Table write into one cell
  typedef struct packed {
    logic            en;
    logic [ZS_W-1:0] zs;
    logic [ZH_W-1:0] zh;
  } cell_load_t;

endpackage

// ===== design/design_region_column_mapper.sv =====
// Design-region column mapper: top level with divider, layer cell chain and result path.
// Depends on drcm_pkg, drcm_div and drcm_cell.
//
// Use: items enter on in_valid/in_ready as in_data. A load item writes one layer's
// z start and height into the cell that owns it; it is taken while idle and gives
// no result. A map item splits cell_index into x and z with two divisions on the
// shared divider (two quotient bits a cycle), then a token walks the eight layer
// cells, one cell a cycle unless held, and each active cell whose z range holds the
// cell, with x in the window, hands a result to a pending register, up to
// RESULT_LIMIT results. The last result of a map item carries last; a map item
// with no match gives one result with hit clear. A map item keeps in_ready low
// until its last result is in the output register; a load item leaves it high.
// Each result waits in the pending register for the next match or for the end
// of the walk before it moves to the output register.
// Results leave through out_valid/out_ready from an output register; while the
// receiver stalls, the walk holds at a matching cell once the pending and output
// registers are full, and the block keeps in_ready low until the map item is done.
// cfg_valid/cfg_ready write one register per handshake; cfg_ready is always high.
// Reset (rst_n low at a clock edge) sets the registers to their defaults, clears
// the layer table and empties the result path.
module design_region_column_mapper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  drcm_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output drcm_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  drcm_pkg::st_t state_r;
  drcm_pkg::st_t state_nxt;

  logic [drcm_pkg::GRID_W-1:0] gx_r;
  logic [drcm_pkg::GRID_W-1:0] gz_r;
  logic [drcm_pkg::XS_W-1:0]   xs_r;
  logic [drcm_pkg::GRID_W-1:0] xw_r;
  logic                        slab_r;
  logic [drcm_pkg::LCNT_W-1:0] lcnt_r;

  logic [drcm_pkg::GRID_W-1:0] nx;
  logic [drcm_pkg::GRID_W-1:0] nz;
  logic                        map_acc;
  logic                        load_acc;

  logic                        div_start;
  logic [drcm_pkg::CELL_W-1:0] div_dividend;
  logic [drcm_pkg::GRID_W-1:0] div_divisor;
  logic                        div_done;
  logic [drcm_pkg::CELL_W-1:0] div_quot;
  logic [drcm_pkg::GRID_W-1:0] div_rem;

  logic [drcm_pkg::CELL_W-1:0] row_r;
  logic                        win_r;
  logic [drcm_pkg::PX_W-1:0]   px_r;
  logic [drcm_pkg::CNT_W-1:0]  cnt_r;
  logic                        win;
  logic [drcm_pkg::XE_W-1:0]   x_end;

  drcm_pkg::out_t              pend_r;
  logic                        pend_v_r;
  drcm_pkg::out_t              out_r;
  logic                        out_v_r;
  drcm_pkg::out_t              new_res;
  drcm_pkg::out_t              fin_res;

  logic                        inject;
  logic                        any_match;
  logic                        match_eff;
  logic [drcm_pkg::LAYER_W-1:0] m_layer;
  logic [drcm_pkg::COL_W-1:0]  m_col;
  logic                        out_free;
  logic                        hold;
  logic                        take_match;
  logic                        walk_done;
  logic                        fin_rel;

  drcm_pkg::cell_cfg_t         cell_cfg;
  drcm_pkg::tok_t              tok_head;
  drcm_pkg::tok_t              tok_o [drcm_pkg::MAX_LAYERS];
  drcm_pkg::cell_hit_t         hits  [drcm_pkg::MAX_LAYERS];

  assign cfg_ready = 1'b1;
  assign map_acc   = in_valid && in_ready && (in_data.action == drcm_pkg::ACT_MAP);
  assign load_acc  = in_valid && in_ready && (in_data.action == drcm_pkg::ACT_LOAD);
  assign nx        = (gx_r == '0) ? drcm_pkg::GRID_W'(1) : gx_r;
  assign nz        = (gz_r == '0) ? drcm_pkg::GRID_W'(1) : gz_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r   <= drcm_pkg::GRID_W'(1);
      gz_r   <= drcm_pkg::GRID_W'(1);
      xs_r   <= '0;
      xw_r   <= '0;
      slab_r <= 1'b0;
      lcnt_r <= drcm_pkg::LCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        drcm_pkg::CFG_GRID_X:  gx_r   <= cfg_data[drcm_pkg::GRID_W-1:0];
        drcm_pkg::CFG_GRID_Z:  gz_r   <= cfg_data[drcm_pkg::GRID_W-1:0];
        drcm_pkg::CFG_X_START: xs_r   <= cfg_data[drcm_pkg::XS_W-1:0];
        drcm_pkg::CFG_X_WIDTH: xw_r   <= cfg_data[drcm_pkg::GRID_W-1:0];
        drcm_pkg::CFG_SLAB:    slab_r <= cfg_data[0];
        drcm_pkg::CFG_LAYERS:  lcnt_r <= cfg_data[drcm_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared divider: x split first, then z split
  drcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Chain of layer cells
  assign cell_cfg.slab        = slab_r;
  assign cell_cfg.width       = xw_r;
  assign cell_cfg.layer_count = lcnt_r;

  assign tok_head.valid = inject;
  assign tok_head.win   = win_r;
  assign tok_head.iz    = div_rem;
  assign tok_head.px    = px_r;
  assign tok_head.base  = '0;

  for (genvar l = 0; l < drcm_pkg::MAX_LAYERS; l++) begin : g_cell
    drcm_pkg::cell_load_t ld;
    drcm_pkg::tok_t       tin;

    assign ld.en = load_acc && (int'(in_data.layer_select) == l);
    assign ld.zs = drcm_pkg::ZS_W'(in_data.layer_z_start_in);
    assign ld.zh = drcm_pkg::ZH_W'(in_data.layer_z_height_in);

    if (l == 0) begin : g_head
      assign tin = tok_head;
    end else begin : g_link
      assign tin = tok_o[l-1];
    end

    drcm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .layer_id (drcm_pkg::LAYER_W'(l)),
      .cfg      (cell_cfg),
      .load     (ld),
      .advance  (!hold),
      .tok_in   (tin),
      .tok_out  (tok_o[l]),
      .hit      (hits[l])
    );
  end

  // Collect the match of the one cell that holds the token
  always_comb begin
    any_match = 1'b0;
    m_layer   = '0;
    m_col     = '0;
    for (int l = 0; l < drcm_pkg::MAX_LAYERS; l++) begin
      if (hits[l].match) begin
        any_match = 1'b1;
        m_layer   = m_layer | hits[l].layer;
        m_col     = m_col | hits[l].col;
      end
    end
  end

  // Result path control
  always_comb begin
    out_free   = !out_v_r || out_ready;
    match_eff  = any_match && (cnt_r < drcm_pkg::CNT_W'(drcm_pkg::RESULT_LIMIT));
    hold       = match_eff && pend_v_r && !out_free;
    take_match = match_eff && !hold;
    walk_done  = tok_o[drcm_pkg::MAX_LAYERS-1].valid && !hold;
    fin_rel    = (state_r == drcm_pkg::ST_FIN) && out_free;
  end

  // X window test on the remainder of the first division
  always_comb begin
    x_end = drcm_pkg::XE_W'(xs_r) + drcm_pkg::XE_W'(xw_r);
    win   = (drcm_pkg::XE_W'(div_rem) >= drcm_pkg::XE_W'(xs_r)) &&
            (drcm_pkg::XE_W'(div_rem) < x_end);
  end

  // Build result words
  always_comb begin
    new_res.row_index     = row_r;
    new_res.hit           = 1'b1;
    new_res.matched_layer = drcm_pkg::ML_W'(m_layer);
    new_res.column_index  = m_col;
    new_res.last          = 1'b0;

    if (pend_v_r) begin
      fin_res      = pend_r;
      fin_res.last = 1'b1;
    end else begin
      fin_res.row_index     = row_r;
      fin_res.hit           = 1'b0;
      fin_res.matched_layer = '0;
      fin_res.column_index  = '0;
      fin_res.last          = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drcm_pkg::ST_IDLE: if (map_acc)   state_nxt = drcm_pkg::ST_DIVX;
      drcm_pkg::ST_DIVX: if (div_done)  state_nxt = drcm_pkg::ST_DIVZ;
      drcm_pkg::ST_DIVZ: if (div_done)  state_nxt = drcm_pkg::ST_WALK;
      drcm_pkg::ST_WALK: if (walk_done) state_nxt = drcm_pkg::ST_FIN;
      drcm_pkg::ST_FIN:  if (out_free)  state_nxt = drcm_pkg::ST_IDLE;
      default:                          state_nxt = drcm_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = in_data.cell_index;
    div_divisor  = nx;
    inject       = 1'b0;
    unique case (state_r)
      drcm_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = map_acc;
      end
      drcm_pkg::ST_DIVX: begin
        div_start    = div_done;
        div_dividend = div_quot;
        div_divisor  = nz;
      end
      drcm_pkg::ST_DIVZ: begin
        inject = div_done;
      end
      drcm_pkg::ST_WALK,
      drcm_pkg::ST_FIN: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= drcm_pkg::ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (inject) begin
        cnt_r <= '0;
      end else if (take_match) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (take_match) begin
        pend_v_r <= 1'b1;
      end else if (fin_rel) begin
        pend_v_r <= 1'b0;
      end

      if (fin_rel || (take_match && pend_v_r)) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (map_acc) begin
      row_r <= in_data.cell_index;
    end
    if ((state_r == drcm_pkg::ST_DIVX) && div_done) begin
      win_r <= win;
      px_r  <= drcm_pkg::PX_W'(div_rem - drcm_pkg::GRID_W'(xs_r));
    end
    if (take_match) begin
      pend_r <= new_res;
    end
    if (fin_rel) begin
      out_r <= fin_res;
    end else if (take_match && pend_v_r) begin
      out_r <= pend_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== design/drcm_div.sv =====
// Iterative unsigned divider, DIV_RADIX quotient bits per cycle.
// Depends on drcm_pkg for widths; divisor must be nonzero.
module drcm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [drcm_pkg::CELL_W-1:0]   dividend,
  input  logic [drcm_pkg::GRID_W-1:0]   divisor,
  output logic                          done,
  output logic [drcm_pkg::CELL_W-1:0]   quot,
  output logic [drcm_pkg::GRID_W-1:0]   rem
);

  logic                             busy_r;
  logic                             done_r;
  logic [drcm_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [drcm_pkg::CELL_W-1:0]      rq_r;
  logic [drcm_pkg::CELL_W-1:0]      rq_nxt;
  logic [drcm_pkg::GRID_W-1:0]      rem_r;
  logic [drcm_pkg::GRID_W-1:0]      rem_nxt;
  logic [drcm_pkg::GRID_W-1:0]      dsr_r;
  logic [drcm_pkg::GRID_W:0]        trial;

  // Retire DIV_RADIX restoring steps: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_nxt = rem_r;
    rq_nxt  = rq_r;
    trial   = '0;
    for (int k = 0; k < drcm_pkg::DIV_RADIX; k++) begin
      trial  = {rem_nxt, rq_nxt[drcm_pkg::CELL_W-1]};
      rq_nxt = {rq_nxt[drcm_pkg::CELL_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial     = trial - {1'b0, dsr_r};
        rq_nxt[0] = 1'b1;
      end
      rem_nxt = trial[drcm_pkg::GRID_W-1:0];
    end
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == drcm_pkg::DIV_CNT_W'(drcm_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      rq_r  <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rq_r  <= rq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = rq_r;
  assign rem  = rem_r;

endmodule

// ===== design/drcm_cell.sv =====
// One layer cell: holds one layer's z range and one stage of the walking token.
// Depends on drcm_pkg for the token, match, load and configuration structs.
module drcm_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [drcm_pkg::LAYER_W-1:0]   layer_id,
  input  drcm_pkg::cell_cfg_t            cfg,
  input  drcm_pkg::cell_load_t           load,
  input  logic                           advance,
  input  drcm_pkg::tok_t                 tok_in,
  output drcm_pkg::tok_t                 tok_out,
  output drcm_pkg::cell_hit_t            hit
);

  logic [drcm_pkg::ZS_W-1:0]  zs_r;
  logic [drcm_pkg::ZH_W-1:0]  zh_r;
  drcm_pkg::tok_t             tok_r;
  logic                       active;
  logic                       in_range;
  logic [drcm_pkg::ZE_W-1:0]  z_end;
  logic [drcm_pkg::IZ_W-1:0]  dz;
  logic [drcm_pkg::IZ_W-1:0]  mul_a;
  logic [drcm_pkg::COL_W-1:0] prod_a;
  logic [drcm_pkg::COL_W-1:0] prod_b;
  logic [drcm_pkg::COL_W-1:0] col;
  logic [drcm_pkg::COL_W-1:0] base_nxt;

  // Write the table entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zs_r <= '0;
      zh_r <= '0;
    end else if (load.en) begin
      zs_r <= load.zs;
      zh_r <= load.zh;
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (advance) begin
      tok_r <= tok_in;
    end
  end

  // Test the z range of this layer
  always_comb begin
    active   = drcm_pkg::ACT_W'(layer_id) < drcm_pkg::ACT_W'(cfg.layer_count);
    z_end    = drcm_pkg::ZE_W'(zs_r) + drcm_pkg::ZE_W'(zh_r);
    in_range = (drcm_pkg::ZE_W'(tok_r.iz) >= drcm_pkg::ZE_W'(zs_r)) &&
               (drcm_pkg::ZE_W'(tok_r.iz) < z_end);
  end

  // Form the column index and the running base
  always_comb begin
    dz       = drcm_pkg::IZ_W'(tok_r.iz - drcm_pkg::IZ_W'(zs_r));
    mul_a    = cfg.slab ? drcm_pkg::IZ_W'(layer_id) : dz;
    prod_a   = drcm_pkg::COL_W'(cfg.width) * drcm_pkg::COL_W'(mul_a);
    prod_b   = drcm_pkg::COL_W'(cfg.width) * drcm_pkg::COL_W'(zh_r);
    col      = drcm_pkg::COL_W'(tok_r.px) + prod_a + (cfg.slab ? '0 : tok_r.base);
    base_nxt = tok_r.base + (cfg.slab ? drcm_pkg::COL_W'(cfg.width) : prod_b);
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.base  = base_nxt;
    hit.match     = tok_r.valid && tok_r.win && active && in_range;
    hit.layer     = layer_id;
    hit.col       = col;
  end

endmodule

// ===== design/drcm_check.sv =====
// Port-level checker for the design-region column mapper, bound to the top level.
// Depends on drcm_pkg for the channel structs and action codes.
module drcm_check (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input drcm_pkg::in_t                     in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input drcm_pkg::out_t                    out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [drcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [drcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Block new items while a map item is in flight
  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == drcm_pkg::ACT_MAP) |=> !in_ready)
    else $error("item accepted during a map item");

  // A load item completes in its own cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == drcm_pkg::ACT_LOAD) |=> in_ready)
    else $error("load item did not complete in one cycle");

  // A no-match result is the lone, final result with zero fields
  a_nomatch_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.last && (out_data.column_index == '0) && (out_data.matched_layer == '0))
    else $error("malformed no-match result");

endmodule

bind design_region_column_mapper drcm_check u_drcm_check (.*);

// ===== sim/drcm_checker.sv =====
// Checker of the design-region column mapper: watches the three channels, predicts
// every result of an accepted map item and compares it with what leaves the block.
// Depends on drcm_pkg.
`timescale 1ns / 1ps

module drcm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  drcm_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  drcm_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [drcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              results_owed
);

  // Own copy of the registers and the layer table
  logic [drcm_pkg::GRID_W-1:0] grid_x;
  logic [drcm_pkg::GRID_W-1:0] grid_z;
  logic [drcm_pkg::XS_W-1:0]   win_start;
  logic [drcm_pkg::GRID_W-1:0] win_width;
  logic                        slab;
  logic [drcm_pkg::LCNT_W-1:0] n_layers;
  logic [drcm_pkg::ZS_W-1:0]   zs_tab [drcm_pkg::MAX_LAYERS];
  logic [drcm_pkg::ZH_W-1:0]   zh_tab [drcm_pkg::MAX_LAYERS];

  drcm_pkg::out_t column_queue [$];
  int             mismatches;

  // Work out the results of one map item and queue them in order
  function automatic void predict_columns(input logic [drcm_pkg::CELL_W-1:0] cell_idx);
    longint unsigned nx, nz, ix, iz, px, base, col, zs, zh, w;
    int             nl;
    int             hits;
    drcm_pkg::out_t found [drcm_pkg::RESULT_LIMIT];
    drcm_pkg::out_t r;
    nx   = (grid_x == '0) ? 1 : grid_x;
    nz   = (grid_z == '0) ? 1 : grid_z;
    ix   = cell_idx % nx;
    iz   = (cell_idx / nx) % nz;
    w    = win_width;
    nl   = (n_layers > drcm_pkg::MAX_LAYERS) ? drcm_pkg::MAX_LAYERS : int'(n_layers);
    hits = 0;
    if (ix >= win_start && ix < longint'(win_start) + w) begin
      px   = ix - win_start;
      base = 0;
      for (int l = 0; l < nl; l++) begin
        zs = zs_tab[l];
        zh = zh_tab[l];
        if (hits < drcm_pkg::RESULT_LIMIT && iz >= zs && iz < zs + zh) begin
          col                      = slab ? px + w * l : px + w * (iz - zs) + base;
          r                        = '0;
          r.row_index              = cell_idx;
          r.hit                    = 1'b1;
          r.matched_layer          = drcm_pkg::ML_W'(l);
          r.column_index           = col[drcm_pkg::COL_W-1:0];
          found[hits]              = r;
          hits++;
        end
        base += slab ? w : w * zh;
      end
    end
    // No match gives one result with hit clear
    if (hits == 0) begin
      r           = '0;
      r.row_index = cell_idx;
      r.last      = 1'b1;
      column_queue.push_back(r);
    end else begin
      for (int k = 0; k < hits; k++) begin
        r      = found[k];
        r.last = (k == hits - 1);
        column_queue.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      grid_x    = 1;
      grid_z    = 1;
      win_start = '0;
      win_width = '0;
      slab      = 1'b0;
      n_layers  = 1;
      for (int i = 0; i < drcm_pkg::MAX_LAYERS; i++) begin
        zs_tab[i] = '0;
        zh_tab[i] = '0;
      end
      column_queue.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          drcm_pkg::CFG_GRID_X:  grid_x    = cfg_data[drcm_pkg::GRID_W-1:0];
          drcm_pkg::CFG_GRID_Z:  grid_z    = cfg_data[drcm_pkg::GRID_W-1:0];
          drcm_pkg::CFG_X_START: win_start = cfg_data[drcm_pkg::XS_W-1:0];
          drcm_pkg::CFG_X_WIDTH: win_width = cfg_data[drcm_pkg::GRID_W-1:0];
          drcm_pkg::CFG_SLAB:    slab      = cfg_data[0];
          drcm_pkg::CFG_LAYERS:  n_layers  = cfg_data[drcm_pkg::LCNT_W-1:0];
          default: ;
        endcase
      end

      // Compare each result with the oldest expectation
      if (out_valid && out_ready) begin
        if (column_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result row %0d hit %0b layer %0d col %0d last %0b",
                     $realtime, out_data.row_index, out_data.hit, out_data.matched_layer,
                     out_data.column_index, out_data.last);
        end else begin
          drcm_pkg::out_t want;
          want = column_queue.pop_front();
          if (out_data.row_index !== want.row_index || out_data.hit !== want.hit ||
              out_data.matched_layer !== want.matched_layer ||
              out_data.column_index !== want.column_index || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected row %0d hit %0b layer %0d col %0d last %0b",
                       $realtime, want.row_index, want.hit, want.matched_layer,
                       want.column_index, want.last);
              $display("%0t:          actual   row %0d hit %0b layer %0d col %0d last %0b",
                       $realtime, out_data.row_index, out_data.hit, out_data.matched_layer,
                       out_data.column_index, out_data.last);
            end
          end
        end
      end

      // Load the table or predict a map item
      if (in_valid && in_ready) begin
        if (in_data.action == drcm_pkg::ACT_LOAD) begin
          if (in_data.layer_select < drcm_pkg::MAX_LAYERS) begin
            zs_tab[in_data.layer_select] = in_data.layer_z_start_in[drcm_pkg::ZS_W-1:0];
            zh_tab[in_data.layer_select] = in_data.layer_z_height_in[drcm_pkg::ZH_W-1:0];
          end
        end else begin
          predict_columns(in_data.cell_index);
        end
      end
    end
    results_owed <= column_queue.size();
    fail_count   <= mismatches;
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top of the design-region column mapper: clock, reset, stimulus and verdict.
// Depends on drcm_pkg, design_region_column_mapper and drcm_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 48;
  localparam logic [drcm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [drcm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  drcm_pkg::in_t                   in_data   = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [drcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [drcm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_ready;
  logic                            out_valid;
  drcm_pkg::out_t                  out_data;
  logic                            cfg_ready;
  int                              fail_count;
  int                              results_owed;
  int                              cycles = 0;
  bit                              steady = 1'b0;

  // Stimulus-side view of the settings, used to aim cells at the layers
  int unsigned sh_gx = 1, sh_gz = 1, sh_xs = 0, sh_xw = 0;
  int unsigned sh_zs [drcm_pkg::MAX_LAYERS];
  int unsigned sh_zh [drcm_pkg::MAX_LAYERS];

  always #5 clk = ~clk;

  design_region_column_mapper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drcm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Receiver: stall a random number of cycles before taking each result
  initial begin
    int unsigned gap;
    forever begin
      gap = draw_wait();
      repeat (gap) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input drcm_pkg::in_t it);
    int unsigned gap;
    gap = draw_wait();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_layer(input int unsigned sel, input int unsigned zs,
                            input int unsigned zh);
    drcm_pkg::in_t it;
    it.action            = drcm_pkg::ACT_LOAD;
    it.cell_index        = drcm_pkg::CELL_W'($urandom);
    it.layer_select      = drcm_pkg::LSEL_W'(sel);
    it.layer_z_start_in  = drcm_pkg::ZIN_W'(zs);
    it.layer_z_height_in = drcm_pkg::HIN_W'(zh);
    sh_zs[sel % drcm_pkg::MAX_LAYERS] = zs;
    sh_zh[sel % drcm_pkg::MAX_LAYERS] = zh;
    send_item(it);
  endtask

  task automatic map_cell(input longint unsigned cell_idx);
    drcm_pkg::in_t it;
    it.action            = drcm_pkg::ACT_MAP;
    it.cell_index        = drcm_pkg::CELL_W'(cell_idx);
    it.layer_select      = drcm_pkg::LSEL_W'($urandom_range(0, 7));
    it.layer_z_start_in  = drcm_pkg::ZIN_W'($urandom_range(0, 4095));
    it.layer_z_height_in = drcm_pkg::HIN_W'($urandom_range(0, 4096));
    send_item(it);
  endtask

  // Write one register; valid stays high for the next write of the group
  task automatic set_reg(input logic [drcm_pkg::CFG_IDX_W-1:0] idx,
                         input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= drcm_pkg::CFG_DATA_W'(val);
    case (idx)
      drcm_pkg::CFG_GRID_X:  sh_gx = val;
      drcm_pkg::CFG_GRID_Z:  sh_gz = val;
      drcm_pkg::CFG_X_START: sh_xs = val;
      drcm_pkg::CFG_X_WIDTH: sh_xw = val;
      default: ;
    endcase
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(input int unsigned gx, input int unsigned gz,
                              input int unsigned xs, input int unsigned xw,
                              input int unsigned slab, input int unsigned lc);
    set_reg(drcm_pkg::CFG_GRID_X, gx);
    set_reg(drcm_pkg::CFG_GRID_Z, gz);
    set_reg(drcm_pkg::CFG_X_START, xs);
    set_reg(drcm_pkg::CFG_X_WIDTH, xw);
    set_reg(drcm_pkg::CFG_SLAB, slab);
    set_reg(drcm_pkg::CFG_LAYERS, lc);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every result is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random settings, mostly small grids with a window inside them
  task automatic rand_config();
    int unsigned gx, gz, xs, xw, nx, lc;
    case ($urandom_range(0, 9))
      0:       gx = 0;
      1:       gx = 4096;
      2:       gx = $urandom_range(1, 4096);
      default: gx = $urandom_range(1, 48);
    endcase
    case ($urandom_range(0, 9))
      0:       gz = 0;
      1:       gz = 4096;
      2:       gz = $urandom_range(1, 4096);
      default: gz = $urandom_range(1, 48);
    endcase
    nx = (gx == 0) ? 1 : gx;
    xs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, nx - 1);
    if ($urandom_range(0, 7) == 0 || xs >= nx) xw = $urandom_range(0, 4096);
    else xw = $urandom_range(1, nx - xs);
    lc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    apply_config(gx, gz, xs, xw, $urandom_range(0, 1), lc);
  endtask

  // Random layer ranges, mostly inside the z extent
  task automatic rand_table();
    int unsigned nz, zs, zh;
    nz = (sh_gz == 0) ? 1 : sh_gz;
    for (int l = 0; l < drcm_pkg::MAX_LAYERS; l++) begin
      zs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, nz - 1);
      zh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, nz);
      load_layer(l, zs, zh);
    end
  endtask

  // Cell inside the window and inside a random layer, now and then in a later grid copy
  function automatic longint unsigned aimed_cell();
    longint unsigned nx, nz, x, z, cell_idx;
    int unsigned l;
    nx = (sh_gx == 0) ? 1 : sh_gx;
    nz = (sh_gz == 0) ? 1 : sh_gz;
    x  = (sh_xw > 0) ? sh_xs + $urandom_range(0, sh_xw - 1) : $urandom_range(0, nx - 1);
    x  = x % nx;
    l  = $urandom_range(0, drcm_pkg::MAX_LAYERS - 1);
    z  = (sh_zh[l] > 0) ? sh_zs[l] + $urandom_range(0, sh_zh[l] - 1)
                        : $urandom_range(0, nz - 1);
    z  = z % nz;
    cell_idx = z * nx + x;
    if ($urandom_range(0, 4) == 0) cell_idx += nx * nz * $urandom_range(1, 3);
    if (cell_idx > 24'hFFFFFF) cell_idx = z * nx + x;
    return cell_idx & 24'hFFFFFF;
  endfunction

  initial begin
    for (int l = 0; l < drcm_pkg::MAX_LAYERS; l++) begin
      sh_zs[l] = 0;
      sh_zh[l] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty window, so both cells miss
    map_cell(0);
    map_cell(24'hFFFFFF);
    settle();

    // Small grid, overlapping layers, an empty layer and one out of reach
    apply_config(16, 16, 2, 10, 0, 8);
    for (int l = 0; l < 6; l++) load_layer(l, l, 3);
    load_layer(6, 0, 0);
    load_layer(7, 4095, 4096);
    map_cell(3 * 16 + 2);        // first x of the window, three layers hold z
    map_cell(11);                // last x of the window
    map_cell(2 * 16 + 1);        // just left of the window
    map_cell(2 * 16 + 12);       // just right of the window
    map_cell(256 + 3 * 16 + 2);  // z wraps around the grid
    settle();

    // Zero grid sizes act as one; every layer covers everything; unused indexes
    set_reg(CFG_SPARE_LO, 13'h1FFF);
    set_reg(CFG_SPARE_HI, 13'h0AAA);
    apply_config(0, 0, 0, 4096, 0, 8);
    for (int l = 0; l < drcm_pkg::MAX_LAYERS; l++) load_layer(l, 0, 4096);
    map_cell(0);
    map_cell(24'hFFFFFF);
    settle();

    // Largest grid, last x start, slab columns, then too many and no layers
    apply_config(4096, 4096, 4095, 1, 1, 15);
    map_cell(4095 + 4096 * 5);
    settle();
    apply_config(4096, 4096, 4095, 4096, 0, 0);
    map_cell(4095 + 4096 * 4095);
    settle();

    // Random phases: new settings and table, then mostly aimed cells
    for (int p = 0; p < 6; p++) begin
      steady = (p == 3);
      rand_config();
      rand_table();
      for (int k = 0; k < 10; k++) begin
        case ($urandom_range(0, 9))
          0:       map_cell($urandom & 24'hFFFFFF);
          1:       load_layer($urandom_range(0, 7), $urandom_range(0, 4095),
                              $urandom_range(0, 4096));
          default: map_cell(aimed_cell());
        endcase
      end
      settle();
    end

    if (fail_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
